[design/wsa_pkg.sv]
// wsa_pkg: shared constants and types for the waveform statistics block
// no dependencies
package wsa_pkg;
    localparam int MaxSamplesDefault = 4096;
    localparam int SampleBitsDefault = 16;
    localparam int TagW = 8;
    localparam int OutW = 16;
    localparam int ClipW = 13;
    localparam int ThrW = 15;
    localparam int VW = 16;
    localparam logic [ThrW-1:0] ClipThrReset = 15'd25300;
    localparam logic [VW-1:0] VMinReset = 16'd20700;
    localparam logic [VW-1:0] VMaxReset = 16'd25300;
    localparam logic [1:0] RegClip = 2'd0;
    localparam logic [1:0] RegVMin = 2'd1;
    localparam logic [1:0] RegVMax = 2'd2;

    typedef struct packed {
        logic accum;    // accumulate the input sample
        logic finish;   // latch record and clear accumulators
        logic start;    // start divide and square root
        logic emit;     // load output register
    } wsa_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
    } wsa_status_t;
endpackage

[design/wsa_if.sv]
// wsa_if: valid/ready channel interfaces for samples and results
// depends on wsa_pkg
interface wsa_in_if import wsa_pkg::*;;
    logic valid;
    logic ready;
    logic signed [SampleBitsDefault-1:0] sample;
    logic [TagW-1:0] phase_tag;
    logic last_sample;
    modport source (output valid, sample, phase_tag, last_sample, input ready);
    modport sink (input valid, sample, phase_tag, last_sample, output ready);
endinterface

interface wsa_out_if import wsa_pkg::*;;
    logic valid;
    logic ready;
    logic [TagW-1:0] phase_label;
    logic signed [OutW-1:0] mean_level;
    logic [OutW-1:0] swing;
    logic [OutW-1:0] rms_value;
    logic [ClipW-1:0] clip_count;
    logic compliant;
    logic overflow;
    modport source (output valid, phase_label, mean_level, swing, rms_value,
        clip_count, compliant, overflow, input ready);
    modport sink (input valid, phase_label, mean_level, swing, rms_value,
        clip_count, compliant, overflow, output ready);
endinterface

[design/wsa_ctrl.sv]
// wsa_ctrl: record sequencer, accumulate / finish / compute / emit
// depends on wsa_pkg
module wsa_ctrl import wsa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    input  logic        out_busy,
    input  wsa_status_t status,
    output wsa_cmd_t    cmd
);
    typedef enum logic [1:0] {S_ACC, S_START, S_CALC, S_EMIT} state_t;
    state_t state_reg;
    logic div_ok_reg, sqrt_ok_reg;

    assign in_ready = (state_reg == S_ACC);

    always_comb
    begin
        cmd.accum  = in_ready && in_valid;
        cmd.finish = in_ready && in_valid && in_last;
        cmd.start  = (state_reg == S_START);
        cmd.emit   = (state_reg == S_EMIT) && !out_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            div_ok_reg <= 1'b0;
            sqrt_ok_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_ACC:
                begin
                    if (in_valid && in_last)
                        state_reg <= S_START;
                end
                S_START:
                begin
                    div_ok_reg <= 1'b0;
                    sqrt_ok_reg <= 1'b0;
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (status.div_done)
                        div_ok_reg <= 1'b1;
                    if (status.sqrt_done)
                        sqrt_ok_reg <= 1'b1;
                    if ((div_ok_reg || status.div_done) && (sqrt_ok_reg || status.sqrt_done))
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_busy)
                        state_reg <= S_ACC;
                end
                default: state_reg <= S_ACC;
            endcase
        end
    end
endmodule

[design/wsa_dp.sv]
// wsa_dp: accumulators, serial divider for mean and mean square, serial square root
// depends on wsa_pkg
module wsa_dp import wsa_pkg::*; #(
    parameter int MAX_SAMPLES = MaxSamplesDefault,
    parameter int SAMPLE_BITS = SampleBitsDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsa_cmd_t                      cmd,
    output wsa_status_t                   status,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [TagW-1:0]               phase_tag,
    input  logic [ThrW-1:0]               clip_thr,
    input  logic [VW-1:0]                 v_min,
    input  logic [VW-1:0]                 v_max,
    output logic [TagW-1:0]               r_label,
    output logic [OutW-1:0]               r_mean,
    output logic [OutW-1:0]               r_p2p,
    output logic [OutW-1:0]               r_rms,
    output logic [ClipW-1:0]              r_clip,
    output logic                          r_comp,
    output logic                          r_ovf
);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = SAMPLE_BITS + CW;
    localparam int QW = 2 * SAMPLE_BITS + CW;     // sum of squares width
    localparam int RW = (QW + 1) / 2;             // root width
    localparam int QCW = $clog2(QW + 1);
    localparam int RCW = $clog2(RW + 1);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_SAMPLES);

    logic signed [SW-1:0] sum_reg;
    logic [QW-1:0] sq_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg, max_reg;
    logic [CW-1:0] cnt_reg, clipc_reg;
    logic ovf_reg;

    // accumulation
    logic acc_ok;
    logic [SAMPLE_BITS-1:0] mag;
    logic signed [SW-1:0] sum_next;
    logic [QW-1:0] sq_next;
    logic signed [SAMPLE_BITS-1:0] min_next, max_next;
    logic [CW-1:0] cnt_next, clipc_next;
    logic ovf_next;

    always_comb
    begin
        acc_ok = cnt_reg != MaxCnt;
        mag = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
        sum_next = sum_reg;
        sq_next = sq_reg;
        min_next = min_reg;
        max_next = max_reg;
        cnt_next = cnt_reg;
        clipc_next = clipc_reg;
        ovf_next = ovf_reg;
        if (acc_ok)
        begin
            sum_next = sum_reg + SW'(sample);
            sq_next = sq_reg + QW'(mag * mag);
            if (cnt_reg == '0 || sample < min_reg)
                min_next = sample;
            if (cnt_reg == '0 || sample > max_reg)
                max_next = sample;
            cnt_next = cnt_reg + 1'b1;
            if ({1'b0, mag} > (SAMPLE_BITS + 1)'(clip_thr))
                clipc_next = clipc_reg + 1'b1;
        end
        else
            ovf_next = 1'b1;
    end

    // latched record
    logic signed [SW-1:0] lsum_reg;
    logic [QW-1:0] lsq_reg;
    logic [SAMPLE_BITS:0] lp2p_reg;
    logic [CW-1:0] lcnt_reg, lclip_reg;
    logic lovf_reg;
    logic [TagW-1:0] ltag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            sq_reg <= '0;
            min_reg <= '0;
            max_reg <= '0;
            cnt_reg <= '0;
            clipc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            sum_reg <= '0;
            sq_reg <= '0;
            min_reg <= '0;
            max_reg <= '0;
            cnt_reg <= '0;
            clipc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.accum)
        begin
            sum_reg <= sum_next;
            sq_reg <= sq_next;
            min_reg <= min_next;
            max_reg <= max_next;
            cnt_reg <= cnt_next;
            clipc_reg <= clipc_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            lsum_reg <= sum_next;
            lsq_reg <= sq_next;
            lp2p_reg <= (SAMPLE_BITS + 1)'(max_next) - (SAMPLE_BITS + 1)'(min_next);
            lcnt_reg <= cnt_next;
            lclip_reg <= clipc_next;
            lovf_reg <= ovf_next;
            ltag_reg <= phase_tag;
        end
    end

    // restoring divider, one quotient bit per cycle, shared for both quotients
    logic [QW-1:0] dq_reg;
    logic [CW:0] drem_reg;
    logic [QCW-1:0] dcnt_reg;
    logic dsel_reg;               // 0: mean of |sum|, 1: mean square
    logic dbusy_reg;
    logic [SW-1:0] mean_mag_reg;
    logic mneg_reg;
    logic [QW-1:0] msq_reg;
    logic [CW:0] dtrial;
    logic [CW:0] dsub;
    logic [SW-1:0] abs_sum;

    assign abs_sum = lsum_reg[SW-1] ? SW'(-lsum_reg) : SW'(lsum_reg);

    always_comb
    begin
        dtrial = {drem_reg[CW-1:0], dq_reg[QW-1]};
        dsub = dtrial - {1'b0, lcnt_reg};
    end

    logic sq_start;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dsel_reg <= 1'b0;
            dcnt_reg <= '0;
            sq_start <= 1'b0;
        end
        else
        begin
            sq_start <= dbusy_reg && dsel_reg && (dcnt_reg == QCW'(1));
            if (cmd.start)
            begin
                dbusy_reg <= 1'b1;
                dsel_reg <= 1'b0;
                dcnt_reg <= QCW'(QW);
                dq_reg <= QW'(abs_sum);
                drem_reg <= '0;
                mneg_reg <= lsum_reg[SW-1];
            end
            else if (dbusy_reg)
            begin
                if (dcnt_reg == QCW'(1) && !dsel_reg)
                begin
                    // mean done, move on to the mean square
                    mean_mag_reg <= SW'({dq_reg[QW-2:0], !dsub[CW]});
                    dsel_reg <= 1'b1;
                    dcnt_reg <= QCW'(QW);
                    dq_reg <= lsq_reg;
                    drem_reg <= '0;
                end
                else
                begin
                    if (!dsub[CW])
                    begin
                        drem_reg <= dsub;
                        dq_reg <= {dq_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dtrial;
                        dq_reg <= {dq_reg[QW-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == QCW'(1))
                    begin
                        msq_reg <= {dq_reg[QW-2:0], !dsub[CW]};
                        dbusy_reg <= 1'b0;
                    end
                end
            end
        end
    end
    assign status.div_done = dbusy_reg && dsel_reg && (dcnt_reg == QCW'(1));

    // digit-by-digit square root, one result bit per cycle
    logic [QW+1:0] sx_reg;
    logic [RW-1:0] sr_reg;
    logic [RW+1:0] srem_reg;
    logic [RCW-1:0] scnt_reg;
    logic sbusy_reg;
    logic [RW+1:0] strial, ssub;

    always_comb
    begin
        strial = {srem_reg[RW-1:0], sx_reg[QW+1:QW]};
        ssub = strial - {sr_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbusy_reg <= 1'b0;
            scnt_reg <= '0;
        end
        else if (sq_start)
        begin
            sbusy_reg <= 1'b1;
            scnt_reg <= RCW'(RW);
            sx_reg <= (QW + 2)'(msq_reg) << ((2 * RW) - QW);
            sr_reg <= '0;
            srem_reg <= '0;
        end
        else if (sbusy_reg)
        begin
            sx_reg <= sx_reg << 2;
            if (!ssub[RW+1])
            begin
                srem_reg <= ssub;
                sr_reg <= {sr_reg[RW-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= strial;
                sr_reg <= {sr_reg[RW-2:0], 1'b0};
            end
            scnt_reg <= scnt_reg - 1'b1;
            if (scnt_reg == RCW'(1))
                sbusy_reg <= 1'b0;
        end
    end
    assign status.sqrt_done = sbusy_reg && (scnt_reg == RCW'(1));

    // results
    logic [SW-1:0] mean_s;
    assign mean_s = mneg_reg ? SW'(-mean_mag_reg) : mean_mag_reg;
    assign r_label = ltag_reg;
    assign r_mean = OutW'(mean_s);
    assign r_p2p = OutW'(lp2p_reg);
    assign r_rms = OutW'(sr_reg);
    assign r_clip = ClipW'(lclip_reg);
    assign r_comp = ((RW + VW)'(sr_reg) >= (RW + VW)'(v_min))
                 && ((RW + VW)'(sr_reg) <= (RW + VW)'(v_max));
    assign r_ovf = lovf_reg;
endmodule

[design/waveform_stats_accumulator.sv]
// waveform_stats_accumulator: running mean / rms / peak-to-peak statistics per record
// throughput: one sample per cycle while accumulating; after the last sample the
//   block holds off input while the bit-serial divider (two quotients) and square root
//   run, and until the result is loaded into the output register
// a result still waiting at the output delays both the new result and the return of input ready
// reset: async active low; accumulators cleared, registers to defaults, output empty
module waveform_stats_accumulator import wsa_pkg::*; #(
    parameter int MAX_SAMPLES = MaxSamplesDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    wsa_in_if.sink      in_ch,
    wsa_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // sample width is fixed by the input channel
    localparam int SAMPLE_BITS = SampleBitsDefault;

    // configuration registers
    logic [ThrW-1:0] clip_thr_reg;
    logic [VW-1:0] v_min_reg, v_max_reg;
    logic [1:0] reg_idx;
    assign reg_idx = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_thr_reg <= ClipThrReset;
            v_min_reg <= VMinReset;
            v_max_reg <= VMaxReset;
        end
        else if (psel && penable && pwrite)
        begin
            // writes beyond the list are dropped
            unique case (reg_idx)
                RegClip: clip_thr_reg <= pwdata[ThrW-1:0];
                RegVMin: v_min_reg <= pwdata[VW-1:0];
                RegVMax: v_max_reg <= pwdata[VW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            RegClip: prdata = 32'(clip_thr_reg);
            RegVMin: prdata = 32'(v_min_reg);
            RegVMax: prdata = 32'(v_max_reg);
            default: prdata = '0;
        endcase
    end

    wsa_cmd_t cmd;
    wsa_status_t status;
    logic in_ready;

    // output register state
    logic out_valid_reg;
    logic [TagW-1:0] r_label;
    logic [OutW-1:0] r_mean, r_p2p, r_rms;
    logic [ClipW-1:0] r_clip;
    logic r_comp, r_ovf;

    assign in_ch.ready = in_ready;

    wsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.last_sample),
        .in_ready (in_ready),
        .out_busy (out_valid_reg && !out_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    wsa_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (in_ch.sample),
        .phase_tag (in_ch.phase_tag),
        .clip_thr  (clip_thr_reg),
        .v_min     (v_min_reg),
        .v_max     (v_max_reg),
        .r_label   (r_label),
        .r_mean    (r_mean),
        .r_p2p     (r_p2p),
        .r_rms     (r_rms),
        .r_clip    (r_clip),
        .r_comp    (r_comp),
        .r_ovf     (r_ovf)
    );

    // result register: holds a request until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_ch.phase_label <= r_label;
            out_ch.mean_level <= r_mean;
            out_ch.swing <= r_p2p;
            out_ch.rms_value <= r_rms;
            out_ch.clip_count <= r_clip;
            out_ch.compliant <= r_comp;
            out_ch.overflow <= r_ovf;
        end
    end
    assign out_ch.valid = out_valid_reg;
endmodule
